/* src/combined_lcg_shuffle_random_generator_defines.svh */
// Assertion macros shared by the combined LCG shuffle generator RTL.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef COMBINED_LCG_SHUFFLE_RANDOM_GENERATOR_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CLSRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CLSRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/clsrg_pkg.sv */
// Package for the combined LCG shuffle generator: widths, moduli and shared types.
// No dependencies; used by clsrg_mulmod, the top level and the testbench.
package clsrg_pkg;

  localparam int unsigned LcgW       = 31;
  localparam int unsigned FracW      = 24;
  localparam int unsigned InDataW    = ((LcgW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = LcgW + FracW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Shuffle table geometry; the slot mapping assumes a power-of-two depth.
  localparam int unsigned TableDepth = 32;
  localparam int unsigned TableAw    = $clog2(TableDepth);
  localparam int unsigned WarmSteps  = TableDepth + 8;
  localparam int unsigned CntW       = $clog2(WarmSteps);

  // Moduli are 2^31 minus a small fold constant, so 2^31 folds back as that constant.
  localparam int unsigned MulW  = 16;
  localparam int unsigned FoldW = 8;
  localparam logic [LcgW-1:0]  Mod1  = 31'd2147483563;
  localparam logic [LcgW-1:0]  Mod2  = 31'd2147483399;
  localparam logic [MulW-1:0]  Mul1  = 16'd40014;
  localparam logic [MulW-1:0]  Mul2  = 16'd40692;
  localparam logic [FoldW-1:0] Fold1 = 8'd85;
  localparam logic [FoldW-1:0] Fold2 = 8'd249;

  localparam logic [LcgW-1:0] Span1       = 31'd2147483562;
  localparam logic [LcgW-1:0] FirstReset  = 31'd1;
  localparam logic [LcgW-1:0] SecondReset = 31'd123456789;
  localparam logic [FracW-1:0] FracMax    = 24'd16777214;

  localparam int unsigned SlotDivInt = 1 + 2147483562 / TableDepth;
  localparam int unsigned SlotShift  = LcgW - TableAw;
  localparam logic [SlotShift:0] SlotDiv = (SlotShift + 1)'(SlotDivInt);

  typedef enum logic {
    GEN_FIRST,
    GEN_SECOND
  } gen_sel_e;

  typedef struct packed {
    logic     start;
    gen_sel_e sel;
  } mul_req_t;

endpackage

/* src/clsrg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module clsrg_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/clsrg_mulmod.sv */
// Shared modular multiplier: x * a mod (2^31 - k) for either generator, three stages.
// Depends on clsrg_pkg.
module clsrg_mulmod import clsrg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mul_req_t        req_i,
  input  logic [LcgW-1:0] operand_i,
  output logic            done_o,
  output logic [LcgW-1:0] result_o
);

  logic [LcgW+MulW-1:0]  prod_d, prod_q;
  logic [MulW-1:0]       mul_k;
  logic [FoldW-1:0]      fold_k;
  logic [MulW+FoldW-1:0] hi_scaled;
  logic [LcgW:0]         fold_d, fold_q;
  logic [LcgW:0]         fold_sub;
  logic [LcgW-1:0]       mod_sel;
  logic [LcgW-1:0]       res_d, res_q;
  gen_sel_e              sel1_q, sel2_q;
  logic                  vld1_q, vld2_q, vld3_q;

  // Stage one: the full product.
  assign mul_k  = (req_i.sel == GEN_SECOND) ? Mul2 : Mul1;
  assign prod_d = {{MulW{1'b0}}, operand_i} * {{LcgW{1'b0}}, mul_k};

  // Stage two: fold the bits above 2^31 back in; the sum stays below twice the modulus.
  assign fold_k    = (sel1_q == GEN_SECOND) ? Fold2 : Fold1;
  assign hi_scaled = {{FoldW{1'b0}}, prod_q[LcgW+MulW-1:LcgW]} * {{MulW{1'b0}}, fold_k};
  assign fold_d    = {1'b0, prod_q[LcgW-1:0]}
                   + {{(LcgW + 1 - MulW - FoldW){1'b0}}, hi_scaled};

  // Stage three: one conditional subtraction.
  assign mod_sel  = (sel2_q == GEN_SECOND) ? Mod2 : Mod1;
  assign fold_sub = fold_q - {1'b0, mod_sel};
  assign res_d    = (fold_q >= {1'b0, mod_sel}) ? fold_sub[LcgW-1:0] : fold_q[LcgW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= req_i.start;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sel1_q <= req_i.sel;
    fold_q <= fold_d;
    sel2_q <= sel1_q;
    res_q  <= res_d;
  end

  assign done_o   = vld3_q;
  assign result_o = res_q;

endmodule

/* src/combined_lcg_shuffle_random_generator.sv */
// Top level of the combined LCG generator with a shuffle table: sequencer and handshakes.
// Depends on clsrg_pkg, clsrg_mulmod, clsrg_ram and the assertion macro header.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser = cmd, tdata = seed_value (32 bits, top bit ignored)
//   m_axis    out        tdata = draw_value, uniform_fraction (56 bits, top bit zero)
//
// A draw runs from acceptance through the slot, multiply and wait states to the
// finishing step that puts the result on m_axis; the three-stage modular
// multiplier is run twice in turn, once per generator. A reseed first runs 40
// warm-up steps on that multiplier, each a request and its result, then goes on as a draw.
// After reset both generators, the last output and the shuffle table hold their
// start values; the table is cleared by per-entry valid bits, not a sweep.
// A new item is taken only while the sequencer is idle; a result held on m_axis
// does not block acceptance, and only the finishing step waits for it to go.
`include "combined_lcg_shuffle_random_generator_defines.svh"

module combined_lcg_shuffle_random_generator import clsrg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // [30:0] seed_value
  input  logic                s_axis_tuser_i,  // [0] cmd
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // [30:0] draw_value, [54:31] uniform_fraction
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_WARM_ISSUE = 3'd1;
  localparam logic [2:0] ST_WARM_WAIT  = 3'd2;
  localparam logic [2:0] ST_SLOT       = 3'd3;
  localparam logic [2:0] ST_MUL1       = 3'd4;
  localparam logic [2:0] ST_WAIT1      = 3'd5;
  localparam logic [2:0] ST_WAIT2      = 3'd6;
  localparam logic [2:0] ST_FIN        = 3'd7;

  logic [2:0]            state_d, state_q;
  logic [LcgW-1:0]       first_d, first_q;
  logic [LcgW-1:0]       second_d, second_q;
  logic [LcgW-1:0]       last_d, last_q;
  logic [CntW-1:0]       cnt_d, cnt_q;
  logic [TableAw-1:0]    slot_d, slot_q;
  logic [TableDepth-1:0] valid_d, valid_q;
  logic                  ent_valid_q;
  logic                  m_valid_d, m_valid_q;
  logic [OutDataW-1:0]   m_data_d, m_data_q;

  logic                  accept;
  logic                  out_free;
  logic                  fin_fire;
  logic [LcgW-1:0]       seed;
  mul_req_t              mul_req;
  logic [LcgW-1:0]       mul_operand;
  logic                  mul_done;
  logic [LcgW-1:0]       mul_res;
  logic                  ram_we;
  logic [TableAw-1:0]    ram_waddr;
  logic [LcgW-1:0]       ram_wdata;
  logic [LcgW-1:0]       ram_rdata;
  logic [LcgW-1:0]       entry;
  logic [TableAw-1:0]    slot_base;
  logic [TableAw:0]      slot_up;
  logic [TableAw:0]      slot_full;
  logic [LcgW+1:0]       slot_prod;
  logic [LcgW+1:0]       diff;
  logic [LcgW+1:0]       wrapped;
  logic [LcgW-1:0]       draw;
  logic [FracW-1:0]      frac;
  logic [LcgW-1:0]       m_draw;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign fin_fire        = (state_q == ST_FIN) && out_free;
  assign seed            = (s_axis_tdata_i[LcgW-1:0] == '0) ? FirstReset
                                                            : s_axis_tdata_i[LcgW-1:0];

  // The multiplier takes a request from the warm-up, from the draw's first multiply step, or
  // straight after the first generator's product returns.
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.sel   = GEN_FIRST;
    if (state_q == ST_WARM_ISSUE || state_q == ST_MUL1) begin
      mul_req.start = 1'b1;
    end else if (state_q == ST_WAIT1 && mul_done) begin
      mul_req.start = 1'b1;
      mul_req.sel   = GEN_SECOND;
    end
  end
  assign mul_operand = (mul_req.sel == GEN_SECOND) ? second_q : first_q;

  clsrg_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .operand_i (mul_operand),
    .done_o    (mul_done),
    .result_o  (mul_res)
  );

  // Warm-up fills entries from the top down; a draw refills the slot it read.
  assign ram_we    = (state_q == ST_WARM_WAIT && mul_done && cnt_q < CntW'(TableDepth))
                  || fin_fire;
  assign ram_waddr = (state_q == ST_FIN) ? slot_q : cnt_q[TableAw-1:0];
  assign ram_wdata = (state_q == ST_FIN) ? first_q : mul_res;

  clsrg_ram #(
    .Width (LcgW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // An entry never written since reset reads as zero.
  assign entry = ent_valid_q ? ram_rdata : '0;

  // Slot = last output divided by a divisor just under 2^SlotShift: the shifted value
  // is the quotient or one short of it, and one product settles which.
  assign slot_base = last_q[LcgW-1:SlotShift];
  assign slot_up   = {1'b0, slot_base} + (TableAw + 1)'(1);
  assign slot_prod = {{(SlotShift + 1){1'b0}}, slot_up} * {{(TableAw + 1){1'b0}}, SlotDiv};
  assign slot_full = (slot_prod <= {2'b00, last_q}) ? slot_up : {1'b0, slot_base};
  assign slot_d    = (slot_full >= (TableAw + 1)'(TableDepth)) ? TableAw'(TableDepth - 1)
                                                              : slot_full[TableAw-1:0];

  // New output: table entry minus the second generator, wrapped up by the span when
  // it is not positive.
  assign diff    = {2'b00, entry} - {2'b00, second_q};
  assign wrapped = (diff[LcgW+1] || diff == '0) ? diff + {2'b00, Span1} : diff;
  assign draw    = wrapped[LcgW-1:0];

  // The Q0.24 fraction is the top 24 bits of the draw, save that all ones is clamped.
  assign frac = (draw[LcgW-1:LcgW-FracW] == '1) ? FracMax : draw[LcgW-1:LcgW-FracW];

  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    second_d  = second_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i) begin
            first_d  = seed;
            second_d = seed;
            cnt_d    = CntW'(WarmSteps - 1);
            state_d  = ST_WARM_ISSUE;
          end else begin
            state_d = ST_SLOT;
          end
        end
      end
      ST_WARM_ISSUE: begin
        state_d = ST_WARM_WAIT;
      end
      ST_WARM_WAIT: begin
        if (mul_done) begin
          first_d = mul_res;
          if (cnt_q < CntW'(TableDepth)) begin
            valid_d[cnt_q[TableAw-1:0]] = 1'b1;
          end
          if (cnt_q == '0) begin
            last_d  = mul_res;
            state_d = ST_SLOT;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = ST_WARM_ISSUE;
          end
        end
      end
      ST_SLOT: begin
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        state_d = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (mul_done) begin
          first_d = mul_res;
          state_d = ST_WAIT2;
        end
      end
      ST_WAIT2: begin
        if (mul_done) begin
          second_d = mul_res;
          state_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          valid_d[slot_q] = 1'b1;
          last_d          = draw;
          m_valid_d       = 1'b1;
          m_data_d        = OutDataW'({frac, draw});
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      first_q   <= FirstReset;
      second_q  <= SecondReset;
      last_q    <= '0;
      cnt_q     <= '0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      first_q   <= first_d;
      second_q  <= second_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (state_q == ST_SLOT) begin
      slot_q <= slot_d;
    end
    ent_valid_q <= valid_q[slot_q];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_draw          = m_data_q[LcgW-1:0];

  `CLSRG_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready_o,
    "input accepted but block still ready in the next cycle")
  `CLSRG_ASSERT_NOW(a_mul_done_expected, mul_done,
    state_q == ST_WARM_WAIT || state_q == ST_WAIT1 || state_q == ST_WAIT2,
    "multiplier result returned while the sequencer was not waiting")
  `CLSRG_ASSERT_NEXT(a_warm_exit, state_q == ST_WARM_WAIT && mul_done && cnt_q == '0,
    state_q == ST_SLOT, "warm-up did not hand over to the draw")
  `CLSRG_ASSERT_NOW(a_draw_range, m_axis_tvalid_o, m_draw != '0 && m_draw <= Span1,
    "draw value outside its range")

endmodule

/* test/tb_combined_lcg_shuffle_random_generator.sv */
// Self-checking testbench for the combined LCG shuffle random generator.
// Depends on clsrg_pkg and the top level; predicts every draw and checks it field by field.
module tb_combined_lcg_shuffle_random_generator;
  import clsrg_pkg::*;

  // Command carried on tuser.
  localparam logic CmdDraw   = 1'b0;
  localparam logic CmdReseed = 1'b1;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned RandomItems = 400;
  // The drain wait outlasts a whole reseed item with margin.
  localparam int unsigned DrainCycles = 250;
  // Worst case is every item a reseed plus sender gaps and receiver stalls,
  // taken several times over.
  localparam int unsigned CycleLimit  = 500000;

  typedef struct packed {
    logic [FracW-1:0] uniform_fraction;
    logic [LcgW-1:0]  draw_value;
  } draw_t;

  // Keeps its own copy of both generators, the last draw and the shuffle table,
  // and queues the draw that each accepted item must produce.
  class draw_scoreboard;
    logic [LcgW-1:0] first_gen;
    logic [LcgW-1:0] second_gen;
    logic [LcgW-1:0] prev_draw;
    logic [LcgW-1:0] slots [TableDepth];
    draw_t           draw_q [$];
    int unsigned     failures;

    function new();
      first_gen  = FirstReset;
      second_gen = SecondReset;
      prev_draw  = '0;
      foreach (slots[i]) slots[i] = '0;
      failures   = 0;
    endfunction

    static function logic [LcgW-1:0] mod_mul(logic [LcgW-1:0] x, logic [MulW-1:0] a,
                                             logic [LcgW-1:0] m);
      logic [63:0] prod;
      prod = 64'(x) * 64'(a);
      return LcgW'(prod % 64'(m));
    endfunction

    function void note_input(logic cmd, logic [LcgW-1:0] seed);
      int unsigned slot;
      longint      diff;
      logic [63:0] scaled;
      draw_t       want;
      if (cmd == CmdReseed) begin
        // A zero seed would lock both generators, so it is taken as one.
        if (seed == '0) seed = FirstReset;
        first_gen  = seed;
        second_gen = seed;
        // Warm-up: the first eight steps are thrown away, the rest fill the
        // table from the top slot down.
        for (int i = int'(WarmSteps) - 1; i >= 0; i--) begin
          first_gen = mod_mul(first_gen, Mul1, Mod1);
          if (i < int'(TableDepth)) slots[i] = first_gen;
        end
        prev_draw = slots[0];
      end
      first_gen  = mod_mul(first_gen, Mul1, Mod1);
      second_gen = mod_mul(second_gen, Mul2, Mod2);
      slot = int'(64'(prev_draw) / 64'(SlotDivInt));
      if (slot >= TableDepth) slot = TableDepth - 1;
      diff = longint'(slots[slot]) - longint'(second_gen);
      slots[slot] = first_gen;
      if (diff < 1) diff += longint'(Span1);
      prev_draw = diff[LcgW-1:0];
      scaled = (64'(prev_draw) << FracW) / 64'd2147483647;
      if (scaled > 64'(FracMax)) scaled = 64'(FracMax);
      want.draw_value       = prev_draw;
      want.uniform_fraction = scaled[FracW-1:0];
      draw_q.push_back(want);
    endfunction

    task report_mismatch(string field, longint unsigned want, longint unsigned got);
      $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $time);
      failures++;
    endtask

    task check_result(logic [OutDataW-1:0] word);
      draw_t got;
      draw_t want;
      got = word[LcgW+FracW-1:0];
      if (draw_q.size() == 0) begin
        report_mismatch("unexpected draw_value", 0, got.draw_value);
      end else begin
        want = draw_q.pop_front();
        if (got.draw_value !== want.draw_value)
          report_mismatch("draw_value", want.draw_value, got.draw_value);
        if (got.uniform_fraction !== want.uniform_fraction)
          report_mismatch("uniform_fraction", want.uniform_fraction, got.uniform_fraction);
      end
    endtask

    function int unsigned pending();
      return draw_q.size();
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;  // [30:0] seed_value
  logic                s_axis_tuser_i  = 1'b0; // [0] cmd
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;   // [30:0] draw_value, [54:31] uniform_fraction

  draw_scoreboard sb = new();

  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_tick  = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  combined_lcg_shuffle_random_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // The receiver rotates a 16-bit ready pattern and swaps in fresh ones, so stalls
  // drift across every phase of the sequencer. Some patterns are all ones,
  // giving stretches with no back-pressure at all.
  always @(posedge clk_i) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 97 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom);
        2:       ready_pattern <= 16'h00FF;
        default: ready_pattern <= 16'($urandom) | 16'($urandom);
      endcase
    end else begin
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
    end
    m_axis_tready_i <= ready_pattern[15];
  end

  // Both handshakes are sampled at the edge, before any driven value changes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_input(s_axis_tuser_i, s_axis_tdata_i[LcgW-1:0]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[combined_lcg_shuffle_random_generator] ERROR");
    $finish;
  end

  // Offers one item and returns at the edge where it is taken. The sender works
  // in bursts; between bursts valid is dropped for a random gap, which may be
  // zero so that back-to-back bursts also occur. The top bit of tdata is not
  // part of the seed and is driven as given to show that it is ignored.
  task automatic send_item(logic cmd, logic [LcgW-1:0] seed, logic upper);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {upper, seed};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
  endtask

  initial begin
    logic             cmd;
    logic [LcgW-1:0]  seed;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Draws on the reset state: an empty table and a zero previous draw.
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdDraw, 31'h7FFFFFFF, 1'b1);
    send_item(CmdDraw, 31'h2AAAAAAA, 1'b0);
    // A zero seed behaves as a seed of one.
    send_item(CmdReseed, '0, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdReseed, 31'd1, 1'b0);
    send_item(CmdDraw, 31'h55555555, 1'b1);
    send_item(CmdReseed, 31'h7FFFFFFF, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    // Seeds equal to a modulus collapse that generator to zero for good.
    send_item(CmdReseed, Mod1, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdReseed, Mod2, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    send_item(CmdDraw, '0, 1'b0);
    // The bit above the seed must not change the seed taken.
    send_item(CmdReseed, 31'd12345, 1'b1);
    send_item(CmdDraw, 31'($urandom), 1'b1);
    send_item(CmdReseed, 31'h40000000, 1'b0);
    send_item(CmdDraw, '0, 1'b0);

    // Mostly draws with an occasional reseed; seeds lean towards the edges.
    repeat (RandomItems) begin
      cmd = ($urandom_range(0, 9) == 0) ? CmdReseed : CmdDraw;
      case ($urandom_range(0, 7))
        0:       seed = 31'($urandom_range(0, 3));
        1:       seed = 31'h7FFFFFFF - 31'($urandom_range(0, 3));
        2:       seed = $urandom_range(0, 1) ? Mod1 : Mod2;
        default: seed = 31'($urandom);
      endcase
      send_item(cmd, seed, 1'($urandom));
    end
    s_axis_tvalid_i <= 1'b0;
    // After this wait the last accepted item is surely on the scoreboard.
    @(posedge clk_i);

    while (sb.pending() != 0) @(posedge clk_i);
    // Let any stray result from a miscounted item show up before judging.
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[combined_lcg_shuffle_random_generator] OK");
    end else begin
      $display("[combined_lcg_shuffle_random_generator] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/clsrg_pkg.sv
src/clsrg_ram.sv
src/clsrg_mulmod.sv
src/combined_lcg_shuffle_random_generator.sv
test/tb_combined_lcg_shuffle_random_generator.sv
